/* rtl/lbs_pkg.sv */
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, widths, opcodes and saturation helpers for the skinning engine.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int DATA_W = 32;
	localparam int ACC_W  = 48;
	localparam int SUM_W  = 50;
	localparam int NUM_W  = 64;
	localparam int DEN_W  = 48;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_LOAD   = 2'd0;
	localparam opcode_t OP_INFL   = 2'd1;
	localparam opcode_t OP_VERTEX = 2'd2;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	function automatic acc_t sat48(input logic signed [64:0] x);
		if (!x[64] && (|x[63:47])) begin
			return {1'b0, {(ACC_W-1){1'b1}}};
		end else if (x[64] && !(&x[63:47])) begin
			return {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			return x[ACC_W-1:0];
		end
	endfunction

	function automatic logic [DATA_W-1:0] sat32(input sum_t x);
		if (!x[SUM_W-1] && (|x[SUM_W-2:31])) begin
			return 32'h7FFF_FFFF;
		end else if (x[SUM_W-1] && !(&x[SUM_W-2:31])) begin
			return 32'h8000_0000;
		end else begin
			return x[DATA_W-1:0];
		end
	endfunction

endpackage

/* rtl/lbs_ram.sv */
// ----------------------------------------------------------------------------
// lbs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/lbs_div.sv */
// ----------------------------------------------------------------------------
// lbs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbs_div import lbs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(NUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* rtl/linear_blend_skinning.sv */
// Load item: written to the palette as it is accepted. Influence item: 16 palette
// reads through the single palette read port, then a MAC drain before the next item.
// Vertex item: 16 blend-matrix reads, then three divisions by w, one per position
// component; when w is zero the divider is skipped.
// arst_n clears control state and the blend matrix (via per-entry valid bits);
// palette contents are undefined until loaded.
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Bone palette skinning engine: blended 4x4 matrix, point and normal transform.
// ----------------------------------------------------------------------------
module linear_blend_skinning import lbs_pkg::*; #(
	parameter int MAX_BONES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [5:0]         bone_index,
	input  logic [3:0]         element_index,
	input  logic signed [31:0] scalar,
	input  logic               first_influence,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] nrm_x,
	input  logic signed [31:0] nrm_y,
	input  logic signed [31:0] nrm_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic signed [31:0] out_nrm_x,
	output logic signed [31:0] out_nrm_y,
	output logic signed [31:0] out_nrm_z,
	output logic               divide_fault
);

	localparam int PAL_D  = MAX_BONES * 16;
	localparam int PAL_AW = $clog2(PAL_D);

	typedef enum logic [2:0] {
		ST_IDLE, ST_RUN, ST_FIN, ST_DIV, ST_DWAIT, ST_OUT
	} state_t;

	state_t state_q;
	logic   accept;
	logic   bone_ok;

	// captured item
	logic               op_inf_q;
	logic [5:0]         bone_q;
	logic               bok_q;
	logic               first_q;
	logic signed [31:0] scalar_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] nrm_q [3];

	// sequencer
	logic [4:0] cnt_q;
	logic       v0;
	logic [1:0] dsel_q;
	logic       pipe_busy;

	// memories
	logic              pal_we;
	logic [PAL_AW-1:0] pal_waddr, pal_raddr;
	logic [31:0]       pal_rd;
	logic              bl_we;
	logic [ACC_W-1:0]  bl_wdata;
	logic [ACC_W-1:0]  bl_rd;
	logic [15:0]       bvld_q;

	// pipeline
	logic               v_s1, v_s2, v_s3;
	logic [3:0]         idx_s1, idx_s2, idx_s3;
	logic               bz_s1;
	acc_t               bval_s1;
	acc_t               m48_s1;
	logic signed [31:0] a_s1, an_s1;
	logic signed [31:0] mh_s1;
	logic signed [16:0] ml_s1;
	logic signed [63:0] ph_s2, pnh_s2;
	logic signed [48:0] pl_s2, pnl_s2;
	acc_t               b_s2, b_s3;
	logic               trans_s2;
	logic signed [64:0] sum_s2, sumn_s2;
	acc_t               term_s3, nterm_s3;
	logic signed [64:0] inf_sum;
	sum_t               pacc_q [4];
	sum_t               nacc_q [4];
	sum_t               pnew, nnew;
	logic               row0_s3, use_n_s3;

	// divide and results
	acc_t               hp_q [4];
	acc_t               hj;
	logic               w_zero;
	logic [ACC_W-1:0]   hj_mag, w_mag;
	logic               neg;
	logic               div_start;
	logic               div_done;
	logic [NUM_W-1:0]   div_quo;
	logic [31:0]        qsat;
	logic [31:0]        pres_q [3];
	logic [31:0]        nres_q [3];
	logic               fault_q;
	logic               out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign bone_ok  = ({3'b0, bone_index} < 9'(MAX_BONES));

	always_ff @(posedge clk) begin
		if (accept) begin
			bone_q    <= bone_index;
			bok_q     <= bone_ok;
			first_q   <= first_influence;
			scalar_q  <= scalar;
			pos_q[0]  <= pos_x;
			pos_q[1]  <= pos_y;
			pos_q[2]  <= pos_z;
			nrm_q[0]  <= nrm_x;
			nrm_q[1]  <= nrm_y;
			nrm_q[2]  <= nrm_z;
		end
	end

	// palette
	assign pal_we    = accept && (opcode == OP_LOAD) && bone_ok;
	assign pal_waddr = PAL_AW'({bone_index, element_index});
	assign pal_raddr = PAL_AW'({bone_q, cnt_q[3:0]});

	lbs_ram #(.WIDTH(32), .DEPTH(PAL_D)) u_pal (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (scalar),
		.raddr (pal_raddr),
		.rdata (pal_rd)
	);

	// blend matrix
	assign bl_we = v_s3 && op_inf_q;
	assign inf_sum = {{16{b_s3[ACC_W-1]}}, b_s3[ACC_W-1], b_s3}
		+ {{16{term_s3[ACC_W-1]}}, term_s3[ACC_W-1], term_s3};
	assign bl_wdata = first_q ? term_s3 : sat48(inf_sum);

	lbs_ram #(.WIDTH(ACC_W), .DEPTH(16)) u_blend (
		.clk   (clk),
		.we    (bl_we),
		.waddr (idx_s3),
		.wdata (bl_wdata),
		.raddr (cnt_q[3:0]),
		.rdata (bl_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvld_q <= '0;
		end else if (bl_we) begin
			bvld_q[idx_s3] <= 1'b1;
		end
	end

	// stage 1: operand select
	assign v0      = (state_q == ST_RUN) && !cnt_q[4];
	assign bval_s1 = bz_s1 ? acc_t'(bl_rd) : '0;
	assign m48_s1  = op_inf_q ? (bok_q ? acc_t'(signed'(pal_rd)) : '0) : bval_s1;
	assign mh_s1   = m48_s1[ACC_W-1:16];
	assign ml_s1   = $signed({1'b0, m48_s1[15:0]});

	always_comb begin
		unique case (idx_s1[3:2])
			2'd0: begin a_s1 = pos_q[0]; an_s1 = nrm_q[0]; end
			2'd1: begin a_s1 = pos_q[1]; an_s1 = nrm_q[1]; end
			2'd2: begin a_s1 = pos_q[2]; an_s1 = nrm_q[2]; end
			default: begin a_s1 = '0; an_s1 = '0; end
		endcase
		if (op_inf_q) begin
			a_s1 = scalar_q;
		end
	end

	// stage 2/3 arithmetic
	assign sum_s2  = {ph_s2[63], ph_s2} + {{32{pl_s2[48]}}, pl_s2[48:16]};
	assign sumn_s2 = {pnh_s2[63], pnh_s2} + {{32{pnl_s2[48]}}, pnl_s2[48:16]};
	assign row0_s3  = (idx_s3[3:2] == 2'd0);
	assign use_n_s3 = (idx_s3[3:2] != 2'd3) && (idx_s3[1:0] != 2'd3);
	assign pnew = (row0_s3 ? sum_t'(0) : pacc_q[0]) + sum_t'(term_s3);
	assign nnew = use_n_s3 ? ((row0_s3 ? sum_t'(0) : nacc_q[0]) + sum_t'(nterm_s3))
		: nacc_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= v0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= cnt_q[3:0];
		bz_s1    <= bvld_q[cnt_q[3:0]];
		idx_s2   <= idx_s1;
		ph_s2    <= a_s1 * mh_s1;
		pl_s2    <= a_s1 * ml_s1;
		pnh_s2   <= an_s1 * mh_s1;
		pnl_s2   <= an_s1 * ml_s1;
		b_s2     <= bval_s1;
		trans_s2 <= !op_inf_q && (idx_s1[3:2] == 2'd3);
		idx_s3   <= idx_s2;
		b_s3     <= b_s2;
		term_s3  <= trans_s2 ? b_s2 : sat48(sum_s2);
		nterm_s3 <= sat48(sumn_s2);
		if (v_s3 && !op_inf_q) begin
			pacc_q[0] <= pacc_q[1];
			pacc_q[1] <= pacc_q[2];
			pacc_q[2] <= pacc_q[3];
			pacc_q[3] <= pnew;
			nacc_q[0] <= nacc_q[1];
			nacc_q[1] <= nacc_q[2];
			nacc_q[2] <= nacc_q[3];
			nacc_q[3] <= nnew;
		end
	end

	assign pipe_busy = v_s1 || v_s2 || v_s3;

	// division by w
	assign hj     = hp_q[dsel_q];
	assign w_zero = (hp_q[3] == '0);
	assign hj_mag = hj[ACC_W-1] ? ACC_W'(-hj) : hj;
	assign w_mag  = hp_q[3][ACC_W-1] ? ACC_W'(-hp_q[3]) : hp_q[3];
	assign neg    = hj[ACC_W-1] ^ hp_q[3][ACC_W-1];
	assign div_start = (state_q == ST_DIV) && !w_zero;

	lbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({hj_mag, 16'h0000}),
		.den    (w_mag),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		if (neg) begin
			qsat = (div_quo > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : 32'(-div_quo);
		end else begin
			qsat = (div_quo > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
		end
	end

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_inf_q     <= 1'b0;
			cnt_q        <= '0;
			dsel_q       <= '0;
			fault_q      <= 1'b0;
			out_valid    <= 1'b0;
			out_pos_x    <= '0;
			out_pos_y    <= '0;
			out_pos_z    <= '0;
			out_nrm_x    <= '0;
			out_nrm_y    <= '0;
			out_nrm_z    <= '0;
			divide_fault <= 1'b0;
		end else begin
			if (out_valid && !out_stall && (state_q != ST_OUT)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == OP_INFL || opcode == OP_VERTEX)) begin
						op_inf_q <= (opcode == OP_INFL);
						cnt_q    <= '0;
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!cnt_q[4]) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!pipe_busy) begin
						state_q <= op_inf_q ? ST_IDLE : ST_FIN;
					end
				end
				ST_FIN: begin
					dsel_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (w_zero) begin
						for (int j = 0; j < 3; j++) begin
							pres_q[j] <= (hp_q[j] == '0) ? 32'h0000_0000 :
								(hp_q[j][ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
						end
						fault_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DWAIT;
					end
				end
				ST_DWAIT: begin
					if (div_done) begin
						pres_q[dsel_q] <= qsat;
						fault_q        <= 1'b0;
						if (dsel_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							dsel_q  <= dsel_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						out_pos_x    <= pres_q[0];
						out_pos_y    <= pres_q[1];
						out_pos_z    <= pres_q[2];
						out_nrm_x    <= nres_q[0];
						out_nrm_y    <= nres_q[1];
						out_nrm_z    <= nres_q[2];
						divide_fault <= fault_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			for (int j = 0; j < 4; j++) begin
				hp_q[j] <= sat48({{15{pacc_q[j][SUM_W-1]}}, pacc_q[j]});
			end
			for (int j = 0; j < 3; j++) begin
				nres_q[j] <= sat32(nacc_q[j]);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !pipe_busy)
		else $error("item accepted while the MAC pipeline is busy");

	a_blend_write_inf: assert property (@(posedge clk) disable iff (!arst_n)
		bl_we |-> (state_q == ST_RUN))
		else $error("blend matrix written outside an influence pass");

	a_div_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !pipe_busy)
		else $error("divide started before the transform pipeline drained");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (w_mag != '0))
		else $error("divider started with a zero denominator");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result presented without a finished vertex");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the skinning engine. Loads bone matrices, blends
// them with weighted influences and transforms vertices, comparing every
// result with a fixed-point predictor under varying input idle and output
// stall pressure.
// ----------------------------------------------------------------------------
import lbs_pkg::*;

typedef logic signed [31:0] vec3_t [3];

typedef struct {
	logic signed [31:0] pos [3];
	logic signed [31:0] nrm [3];
	logic               fault;
} skin_result_t;

class skin_scoreboard;
	logic signed [31:0] palette [1024];
	bit                 written [1024];
	longint             blend [16];
	skin_result_t       pending [$];
	int                 errors;

	function new();
		foreach (blend[k]) blend[k] = 0;
		foreach (written[k]) written[k] = 0;
		errors = 0;
	endfunction

	function longint clamp48(longint x);
		if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
		if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
		return x;
	endfunction

	function logic signed [31:0] clamp32(longint x);
		if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
		if (x < -64'sh8000_0000) return 32'h8000_0000;
		return x[31:0];
	endfunction

	function longint scale_q(longint a, longint m);
		longint mh, ml;
		mh = m >>> 16;
		ml = m - mh * 65536;
		return clamp48(mh * a + ((a * ml) >>> 16));
	endfunction

	function bit bone_ready(int b);
		for (int k = 0; k < 16; k++) if (!written[b * 16 + k]) return 0;
		return 1;
	endfunction

	function void note(opcode_t op, logic [5:0] bone, logic [3:0] elem,
			logic signed [31:0] sc, logic first, vec3_t p, vec3_t n);
		skin_result_t r;
		longint hp [4];
		longint acc, num, term, q;
		if (op == OP_LOAD) begin
			palette[bone * 16 + elem] = sc;
			written[bone * 16 + elem] = 1;
		end else if (op == OP_INFL) begin
			for (int k = 0; k < 16; k++) begin
				term = clamp48((longint'(sc) * longint'(palette[bone * 16 + k])) >>> 16);
				blend[k] = first ? term : clamp48(blend[k] + term);
			end
		end else if (op == OP_VERTEX) begin
			for (int j = 0; j < 4; j++) begin
				acc = blend[12 + j];
				for (int i = 0; i < 3; i++) acc += scale_q(p[i], blend[i * 4 + j]);
				hp[j] = clamp48(acc);
			end
			r.fault = (hp[3] == 0);
			for (int j = 0; j < 3; j++) begin
				if (hp[3] == 0) begin
					r.pos[j] = hp[j] > 0 ? 32'h7FFF_FFFF : (hp[j] < 0 ? 32'h8000_0000 : 0);
				end else begin
					num = hp[j] * 65536;
					if (num == 64'h8000_0000_0000_0000 && hp[3] == -1) q = 64'sh7FFF_FFFF_FFFF_FFFF;
					else q = num / hp[3];
					r.pos[j] = clamp32(q);
				end
				acc = 0;
				for (int i = 0; i < 3; i++) acc += scale_q(n[i], blend[i * 4 + j]);
				r.nrm[j] = clamp32(clamp48(acc));
			end
			pending.push_back(r);
		end
	endfunction

	function void check(skin_result_t got);
		skin_result_t e;
		string pn [3] = '{"out_pos_x", "out_pos_y", "out_pos_z"};
		string nn [3] = '{"out_nrm_x", "out_nrm_y", "out_nrm_z"};
		if (pending.size() == 0) begin
			$error("unexpected result item");
			errors++;
			return;
		end
		e = pending.pop_front();
		for (int j = 0; j < 3; j++) begin
			if (got.pos[j] !== e.pos[j]) begin
				$error("%s expected %0d actual %0d", pn[j], e.pos[j], got.pos[j]);
				errors++;
			end
			if (got.nrm[j] !== e.nrm[j]) begin
				$error("%s expected %0d actual %0d", nn[j], e.nrm[j], got.nrm[j]);
				errors++;
			end
		end
		if (got.fault !== e.fault) begin
			$error("divide_fault expected %0d actual %0d", e.fault, got.fault);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam opcode_t OP_NONE = 2'd3;
	localparam int LIMIT = 1500000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic [1:0]         opcode = 0;
	logic [5:0]         bone_index = 0;
	logic [3:0]         element_index = 0;
	logic signed [31:0] scalar = 0;
	logic               first_influence = 0;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [31:0] nrm_x = 0, nrm_y = 0, nrm_z = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
	logic signed [31:0] out_nrm_x, out_nrm_y, out_nrm_z;
	logic               divide_fault;

	skin_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;
	int ready_bones [$];

	linear_blend_skinning u_dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	always @(negedge clk) begin
		skin_result_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.pos = '{out_pos_x, out_pos_y, out_pos_z};
			r.nrm = '{out_nrm_x, out_nrm_y, out_nrm_z};
			r.fault = divide_fault;
			sb.check(r);
		end
	end

	task automatic send(opcode_t op, logic [5:0] bone, logic [3:0] elem,
			logic signed [31:0] sc, logic first, vec3_t p, vec3_t n);
		bit take;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		bone_index <= bone;
		element_index <= elem;
		scalar <= sc;
		first_influence <= first;
		{pos_x, pos_y, pos_z} <= {p[0], p[1], p[2]};
		{nrm_x, nrm_y, nrm_z} <= {n[0], n[1], n[2]};
		do begin
			@(negedge clk);
			take = !in_stall;
			@(posedge clk);
		end while (!take);
		sb.note(op, bone, elem, sc, first, p, n);
	endtask

	function automatic logic signed [31:0] rnd_q();
		unique case ($urandom_range(7))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $signed($urandom_range(32'h40000)) - 32'sh20000;
		endcase
	endfunction

	function automatic vec3_t rnd_vec();
		vec3_t v;
		foreach (v[i]) v[i] = rnd_q();
		return v;
	endfunction

	task automatic load_bone(int b);
		for (int k = 0; k < 16; k++)
			send(OP_LOAD, 6'(b), 4'(k), rnd_q(), 1'($urandom), rnd_vec(), rnd_vec());
		if (!(b inside {ready_bones})) ready_bones.push_back(b);
	endtask

	task automatic random_phase(int count);
		int done_items = 0;
		int pick, b;
		while (done_items < count) begin
			pick = $urandom_range(99);
			if (pick < 15 || ready_bones.size() == 0) begin
				load_bone($urandom_range(63));
				done_items += 16;
			end else if (pick < 25) begin
				send(OP_LOAD, 6'($urandom), 4'($urandom), rnd_q(), 1'($urandom), rnd_vec(),
					rnd_vec());
				done_items++;
			end else if (pick < 65) begin
				b = ready_bones[$urandom_range(ready_bones.size() - 1)];
				send(OP_INFL, 6'(b), 4'($urandom), rnd_q(), $urandom_range(2) == 0, rnd_vec(),
					rnd_vec());
				done_items++;
			end else if (pick < 95) begin
				send(OP_VERTEX, 6'($urandom), 4'($urandom), $urandom, 1'($urandom), rnd_vec(),
					rnd_vec());
				done_items++;
			end else begin
				send(OP_NONE, 6'($urandom), 4'($urandom), $urandom, 1'($urandom), rnd_vec(),
					rnd_vec());
			end
		end
	endtask

	initial begin
		logic signed [31:0] dir [16];
		vec3_t ext_hi, ext_lo, unit;
		ext_hi = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		ext_lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		unit = '{32'h10000, 32'sh20000, -32'sh30000};
		dir = '{32'h10000, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 32'h10000, 0, 0,
			0, 0, 32'h10000, 32'h8000, 32'h5000, -32'sh7000, 32'h1234, 32'h10000};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int k = 0; k < 16; k++) send(OP_LOAD, 6'd63, 4'(k), dir[k], k[0], ext_hi, ext_lo);
		ready_bones.push_back(63);
		send(OP_VERTEX, 0, 0, 0, 0, unit, unit);
		send(OP_INFL, 63, 0, 32'h10000, 1, unit, unit);
		send(OP_VERTEX, 0, 0, 0, 0, unit, ext_hi);
		send(OP_INFL, 63, 0, 32'h7FFF_FFFF, 0, unit, unit);
		send(OP_VERTEX, 63, 15, 32'hFFFF_FFFF, 1, ext_lo, ext_hi);
		send(OP_INFL, 63, 0, 32'h8000_0000, 1, unit, unit);
		send(OP_VERTEX, 0, 0, 0, 0, ext_hi, ext_lo);
		send(OP_NONE, 63, 15, 32'hFFFF_FFFF, 1, ext_hi, ext_hi);
		send(OP_INFL, 63, 0, 0, 1, unit, unit);
		send(OP_VERTEX, 0, 0, 0, 0, unit, unit);

		idle_pct = 0;  stall_pct = 0;  random_phase(150);
		idle_pct = 66; stall_pct = 0;  random_phase(150);
		idle_pct = 0;  stall_pct = 66; random_phase(150);
		idle_pct = 37; stall_pct = 37; random_phase(150);

		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule

/* filelist.f */
rtl/lbs_pkg.sv
rtl/lbs_ram.sv
rtl/lbs_div.sv
rtl/linear_blend_skinning.sv
verif/testbench.sv
